// ===== src/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// shared constants and types for the sorted key table
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int Capacity   = 64;
  localparam int KeyWidth   = 16;
  localparam int ValueWidth = 16;
  localparam int AddrWidth  = $clog2(Capacity);
  localparam int CountWidth = $clog2(Capacity + 1);
  localparam int EntryWidth = KeyWidth + ValueWidth;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd1;
  localparam logic [2:0] ST_FULL         = 3'd2;
  localparam logic [2:0] ST_DUPLICATE    = 3'd3;
  localparam logic [2:0] ST_BAD_POSITION = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_WAIT,
    S_CHECK,
    S_SHIFT,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [AddrWidth-1:0]  waddr;
    logic [EntryWidth-1:0] wdata;
    logic [AddrWidth-1:0]  raddr;
  } mem_req_t;

endpackage

// ===== src/sorted_key_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_unit
// sorted key/value table, descending keys, binary search plus shift moves
// ----------------------------------------------------------------------------
//  channel  signals                                           handshake
//  command  func key value position                           start, busy
//  result   status found_position key_out value_out entry_count  done strobe
//
//  lookup: binary search, halving the range each step, then a check of the slot
//  insert moves every entry after the slot up one place, remove moves them down
//  busy is high after accept through the done cycle; done pulses one cycle
//  rst clears the count and control; stored entries stay undefined
// ----------------------------------------------------------------------------
module sorted_key_table_unit
  import skt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func,
  input  logic [KeyWidth-1:0]   key,
  input  logic [ValueWidth-1:0] value,
  input  logic [AddrWidth-1:0]  position,
  output logic                  done,
  output logic [2:0]            status,
  output logic [AddrWidth-1:0]  found_position,
  output logic [KeyWidth-1:0]   key_out,
  output logic [ValueWidth-1:0] value_out,
  output logic [CountWidth-1:0] entry_count
);

  state_t                state, state_next;
  logic [1:0]            op;
  logic [KeyWidth-1:0]   k;
  logic [ValueWidth-1:0] v;
  logic [AddrWidth-1:0]  pos;
  logic [CountWidth-1:0] count, count_next;
  logic [CountWidth-1:0] lo, lo_next, hi, hi_next, mid;
  logic [CountWidth-1:0] idx, idx_next;
  logic [2:0]            st_next;
  logic [AddrWidth-1:0]  fp_next;
  logic [KeyWidth-1:0]   ko_next;
  logic [ValueWidth-1:0] vo_next;
  logic                  done_next;
  logic [EntryWidth-1:0] rdata;
  logic [KeyWidth-1:0]   rkey;
  mem_req_t              req;
  logic                  hit;

  skt_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  assign rkey = rdata[EntryWidth-1:ValueWidth];
  assign mid  = lo + ((hi - lo) >> 1);
  assign hit  = (lo < count) && (rkey == k);
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    lo  <= lo_next;
    hi  <= hi_next;
    idx <= idx_next;
    if (done_next) begin
      status         <= st_next;
      found_position <= fp_next;
      key_out        <= ko_next;
      value_out      <= vo_next;
      entry_count    <= count_next;
    end
    if (start && !busy) begin
      op  <= func;
      k   <= key;
      v   <= value;
      pos <= position;
    end else if (state == S_CHECK && op == FUNC_REMOVE) begin
      // keep the removed entry's value for the result
      v <= rdata[ValueWidth-1:0];
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    lo_next    = lo;
    hi_next    = hi;
    idx_next   = idx;
    done_next  = 1'b0;
    st_next    = ST_OK;
    fp_next    = '0;
    ko_next    = '0;
    vo_next    = '0;
    req.we     = 1'b0;
    req.waddr  = idx[AddrWidth-1:0];
    req.wdata  = {k, v};
    req.raddr  = mid[AddrWidth-1:0];
    case (state)
      S_IDLE: begin
        if (start) begin
          lo_next    = '0;
          hi_next    = count;
          state_next = (func == FUNC_READ) ? S_READ : S_SEARCH;
        end
      end
      S_SEARCH: begin
        // binary search for slot: count of keys greater than k
        if (lo < hi) begin
          state_next = S_WAIT;
        end else begin
          req.raddr  = lo[AddrWidth-1:0];
          state_next = S_CHECK;
        end
      end
      S_WAIT: begin
        if (rkey > k) begin
          lo_next = mid + 1'b1;
        end else begin
          hi_next = mid;
        end
        state_next = S_SEARCH;
      end
      S_CHECK: begin
        fp_next = lo[AddrWidth-1:0];
        ko_next = rkey;
        vo_next = rdata[ValueWidth-1:0];
        case (op)
          FUNC_INSERT: begin
            if (hit) begin
              st_next    = ST_DUPLICATE;
              done_next  = 1'b1;
              state_next = S_DONE;
            end else if (count >= CountWidth'(Capacity)) begin
              st_next    = ST_FULL;
              fp_next    = '0;
              ko_next    = '0;
              vo_next    = '0;
              done_next  = 1'b1;
              state_next = S_DONE;
            end else begin
              idx_next   = count;
              req.raddr  = AddrWidth'(count - 1'b1);
              state_next = S_SHIFT;
            end
          end
          FUNC_REMOVE: begin
            if (!hit) begin
              st_next    = ST_NOT_FOUND;
              fp_next    = '0;
              ko_next    = '0;
              vo_next    = '0;
              done_next  = 1'b1;
              state_next = S_DONE;
            end else begin
              done_next  = 1'b0;
              idx_next   = lo;
              req.raddr  = AddrWidth'(lo + 1'b1);
              state_next = S_SHIFT;
            end
          end
          default: begin
            if (!hit && op == FUNC_LOOKUP) begin
              st_next = ST_NOT_FOUND;
              fp_next = '0;
              ko_next = '0;
              vo_next = '0;
            end
            done_next  = 1'b1;
            state_next = S_DONE;
          end
        endcase
      end
      S_SHIFT: begin
        if (op == FUNC_INSERT) begin
          if (idx > lo) begin
            req.we     = 1'b1;
            req.wdata  = rdata;
            idx_next   = idx - 1'b1;
            req.raddr  = AddrWidth'(idx - 2'd2);
          end else begin
            req.we     = 1'b1;
            count_next = count + 1'b1;
            st_next    = ST_OK;
            fp_next    = lo[AddrWidth-1:0];
            ko_next    = k;
            vo_next    = v;
            done_next  = 1'b1;
            state_next = S_DONE;
          end
        end else begin
          if (idx + 1'b1 < count) begin
            req.we    = 1'b1;
            req.wdata = rdata;
            idx_next  = idx + 1'b1;
            req.raddr = AddrWidth'(idx + 2'd2);
          end else begin
            count_next = count - 1'b1;
            idx_next   = lo;
            req.raddr  = '0;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        // read op: fetch position; remove op: wait then report saved entry
        if (op == FUNC_READ) begin
          req.raddr  = pos;
          state_next = S_CHECK;
          lo_next    = {1'b0, pos};
          if ({1'b0, pos} >= count) begin
            st_next    = ST_BAD_POSITION;
            done_next  = 1'b1;
            state_next = S_DONE;
          end
        end else begin
          st_next    = ST_OK;
          fp_next    = lo[AddrWidth-1:0];
          ko_next    = k;
          vo_next    = v;
          done_next  = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/skt_ram.sv =====
// ----------------------------------------------------------------------------
// skt_ram
// entry memory: one write port, one registered read port
// ----------------------------------------------------------------------------
module skt_ram
  import skt_pkg::*;
(
  input  logic                  clk,
  input  mem_req_t              req,
  output logic [EntryWidth-1:0] rdata
);

  logic [EntryWidth-1:0] mem [Capacity];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== verif/sorted_key_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_unit_tb
// self-checking bench: directed table, fill/drain, then random insert/remove/
// lookup/read words, each result compared with a behavioral table in the bench
// ----------------------------------------------------------------------------
module sorted_key_table_unit_tb
  import skt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]            status;
    logic [AddrWidth-1:0]  fpos;
    logic [KeyWidth-1:0]   kout;
    logic [ValueWidth-1:0] vout;
    logic [CountWidth-1:0] count;
  } outcome_t;

  typedef struct {
    logic [1:0]            func;
    logic [KeyWidth-1:0]   key;
    logic [ValueWidth-1:0] value;
    logic [AddrWidth-1:0]  position;
    bit                    typed;
    logic [2:0]            status;
    logic [CountWidth-1:0] count;
  } step_t;

  logic clk = 0, rst = 1, start = 0;
  logic [1:0] func = FUNC_INSERT;
  logic [KeyWidth-1:0] key = '0;
  logic [ValueWidth-1:0] value = '0;
  logic [AddrWidth-1:0] position = '0;
  logic busy, done;
  logic [2:0] status;
  logic [AddrWidth-1:0] found_position;
  logic [KeyWidth-1:0] key_out;
  logic [ValueWidth-1:0] value_out;
  logic [CountWidth-1:0] entry_count;

  sorted_key_table_unit dut (.*);

  always #5 clk = ~clk;

  logic [KeyWidth-1:0]   tbl_key [Capacity];
  logic [ValueWidth-1:0] tbl_val [Capacity];
  int tbl_count = 0;
  outcome_t pending_results[$];
  int mismatches = 0, idle_cycles = 0;
  bit quiet = 0;

  function automatic int sorted_slot(logic [KeyWidth-1:0] k);
    int lo, hi, mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (tbl_key[mid] > k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic outcome_t apply_word(logic [1:0] f, logic [KeyWidth-1:0] k,
                                          logic [ValueWidth-1:0] v,
                                          logic [AddrWidth-1:0] p);
    outcome_t r;
    int s;
    bit hit;
    r = '{ST_OK, '0, '0, '0, '0};
    s = sorted_slot(k);
    hit = s < tbl_count && tbl_key[s] == k;
    case (f)
      FUNC_INSERT: begin
        if (hit) begin
          r.status = ST_DUPLICATE;
          r.fpos = AddrWidth'(s); r.kout = tbl_key[s]; r.vout = tbl_val[s];
        end else if (tbl_count >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          for (int i = tbl_count; i > s; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_val[i] = tbl_val[i-1];
          end
          tbl_key[s] = k; tbl_val[s] = v; tbl_count++;
          r.fpos = AddrWidth'(s); r.kout = k; r.vout = v;
        end
      end
      FUNC_REMOVE, FUNC_LOOKUP: begin
        if (!hit) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.fpos = AddrWidth'(s); r.kout = tbl_key[s]; r.vout = tbl_val[s];
          if (f == FUNC_REMOVE) begin
            for (int i = s; i + 1 < tbl_count; i++) begin
              tbl_key[i] = tbl_key[i+1];
              tbl_val[i] = tbl_val[i+1];
            end
            tbl_count--;
          end
        end
      end
      default: begin
        if (p >= tbl_count) begin
          r.status = ST_BAD_POSITION;
        end else begin
          r.fpos = p; r.kout = tbl_key[p]; r.vout = tbl_val[p];
        end
      end
    endcase
    r.count = CountWidth'(tbl_count);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, exp_v, act_v);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report("unexpected word", 0, 1);
      end else begin
        outcome_t e;
        e = pending_results.pop_front();
        if (status !== e.status) report("status", 32'(e.status), 32'(status));
        if (found_position !== e.fpos)
          report("found_position", 32'(e.fpos), 32'(found_position));
        if (key_out !== e.kout) report("key_out", 32'(e.kout), 32'(key_out));
        if (value_out !== e.vout) report("value_out", 32'(e.vout), 32'(value_out));
        if (entry_count !== e.count)
          report("entry_count", 32'(e.count), 32'(entry_count));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] f, logic [KeyWidth-1:0] k,
                           logic [ValueWidth-1:0] v, logic [AddrWidth-1:0] p,
                           bit typed, logic [2:0] st, logic [CountWidth-1:0] cnt);
    outcome_t r;
    while (!quiet && $urandom_range(99) < 24) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; func <= f; key <= k; value <= v; position <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_word(f, k, v, p);
    if (typed) begin
      r.status = st;
      r.count = cnt;
    end
    pending_results.push_back(r);
  endtask

  function automatic logic [KeyWidth-1:0] pick_key();
    if (tbl_count > 0 && $urandom_range(99) < 60)
      return tbl_key[$urandom_range(tbl_count - 1)];
    return $urandom_range(99) < 50 ? KeyWidth'($urandom) : KeyWidth'($urandom_range(40));
  endfunction

  step_t steps[$];

  initial begin
    int n;
    logic [1:0] f;
    steps = '{
      '{FUNC_READ,   16'h0000, 16'h0000, 6'd0,  1, ST_BAD_POSITION, 7'd0},
      '{FUNC_LOOKUP, 16'h1234, 16'h0000, 6'd0,  1, ST_NOT_FOUND,    7'd0},
      '{FUNC_REMOVE, 16'hffff, 16'h0000, 6'd0,  1, ST_NOT_FOUND,    7'd0},
      '{FUNC_INSERT, 16'hffff, 16'hffff, 6'd0,  1, ST_OK,           7'd1},
      '{FUNC_INSERT, 16'h0000, 16'h0000, 6'd0,  1, ST_OK,           7'd2},
      '{FUNC_INSERT, 16'h8000, 16'h5a5a, 6'd0,  1, ST_OK,           7'd3},
      '{FUNC_INSERT, 16'h8000, 16'h1111, 6'd0,  1, ST_DUPLICATE,    7'd3},
      '{FUNC_INSERT, 16'h7fff, 16'ha5a5, 6'd63, 0, 0, 0},
      '{FUNC_LOOKUP, 16'h0000, 16'h0000, 6'd0,  0, 0, 0},
      '{FUNC_LOOKUP, 16'hffff, 16'h0000, 6'd0,  0, 0, 0},
      '{FUNC_READ,   16'h0000, 16'h0000, 6'd3,  0, 0, 0},
      '{FUNC_READ,   16'h0000, 16'h0000, 6'd4,  1, ST_BAD_POSITION, 7'd4},
      '{FUNC_READ,   16'hffff, 16'hffff, 6'd63, 1, ST_BAD_POSITION, 7'd4},
      '{FUNC_REMOVE, 16'h8000, 16'h0000, 6'd0,  0, 0, 0},
      '{FUNC_REMOVE, 16'h8000, 16'h0000, 6'd0,  1, ST_NOT_FOUND,    7'd3},
      '{FUNC_REMOVE, 16'hffff, 16'h0000, 6'd0,  0, 0, 0},
      '{FUNC_READ,   16'h0000, 16'h0000, 6'd0,  0, 0, 0}
    };
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (steps[i])
      send_word(steps[i].func, steps[i].key, steps[i].value, steps[i].position,
                steps[i].typed, steps[i].status, steps[i].count);
    // fill to capacity, then overflow and drain
    while (tbl_count < Capacity)
      send_word(FUNC_INSERT, KeyWidth'($urandom), ValueWidth'($urandom), '0, 0, 0, 0);
    send_word(FUNC_INSERT, 16'h0001, 16'h0001, '0, 0, 0, 0);
    send_word(FUNC_READ, '0, '0, 6'd63, 0, 0, 0);
    start <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    while (tbl_count > 0)
      send_word(FUNC_REMOVE, tbl_key[$urandom_range(tbl_count - 1)], '0, '0, 0, 0, 0);
    for (n = 0; n < 1550; n++) begin
      quiet = n >= 600 && n < 900;
      f = 2'($urandom_range(3));
      if (tbl_count < 20 && $urandom_range(99) < 40) f = FUNC_INSERT;
      send_word(f, pick_key(), ValueWidth'($urandom),
                $urandom_range(99) < 80 && tbl_count > 0 ?
                  AddrWidth'($urandom_range(tbl_count - 1)) : AddrWidth'($urandom),
                0, 0, 0);
    end
    start <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/skt_pkg.sv
src/skt_ram.sv
src/sorted_key_table_unit.sv
verif/sorted_key_table_unit_tb.sv
